FILE: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam int unsigned KIND_W    = 3;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned HALF_W    = 8;
   localparam int unsigned TIMEOUT_W = 10;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 10;

   localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_START = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ACK   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_NACK  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_CHECK = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 1'd1;

   localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd6;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd100;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              drive;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] read_data;
      logic              ack_seen;
      logic              rejected;
   } tick_res_type;

endpackage

FILE: src/i2c_master_byte_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_core
// I2C master line sequencer driven by one tick word per bus time step.
// ----------------------------------------------------------------------------
// One tick word is taken per clock and gives exactly one result word through
// an output register backed by a one-word skid stage; req_tready drops only
// while that skid stage is full. The phase sequencer state advances once per
// accepted tick, so bus timing is set by the tick stream and the half-period
// and ACK-timeout registers, not by the clock.
module i2c_master_byte_sequencer_core
   import i2cms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // tx_byte[7:0], sda_in[8], zero[15:9]
   input  logic [KIND_W-1:0]    req_tuser,   // kind[2:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // scl[0], sda[1], sda_drive[2], busy[3],
                                             // done[4], read_data[12:5], ack_seen[13],
                                             // rejected[14], zero[15]
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [HALF_W-1:0]    half_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 accept;
   logic                 pop;
   tick_res_type         res;
   logic [15:0]          word;
   logic                 out_valid_ff, out_valid_in;
   logic [15:0]          out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [15:0]          skid_data_ff, skid_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= HALF_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_ff    <= csr_wdata[HALF_W-1:0];
            CSR_ACK_TIMEOUT: timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   i2cms_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .kind        (req_tuser),
      .tx_byte     (req_tdata[7:0]),
      .sda_in      (req_tdata[8]),
      .half_period (half_ff),
      .ack_timeout (timeout_ff),
      .res         (res)
   );

   assign word = {1'b0, res.rejected, res.ack_seen, res.read_data, res.done,
                  res.busy, res.drive, res.sda, res.scl};

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = word;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: src/i2cms_engine.sv
// ----------------------------------------------------------------------------
// i2cms_engine
// Phase sequencer: one tick per step, line levels and command results.
// ----------------------------------------------------------------------------
module i2cms_engine
   import i2cms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [KIND_W-1:0]    kind,
   input  logic [BYTE_W-1:0]    tx_byte,
   input  logic                 sda_in,
   input  logic [HALF_W-1:0]    half_period,
   input  logic [TIMEOUT_W-1:0] ack_timeout,
   output tick_res_type         res
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_SP0, PH_SP1, PH_SP2,
      PH_WL, PH_WH, PH_WT, PH_RL0, PH_RH, PH_RL,
      PH_AK0, PH_AK1, PH_AK2, PH_CK0, PH_CK1, PH_CKP, PH_CKT
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [KIND_W-1:0]    cmd;
      logic [3:0]           bits;
      logic [BYTE_W-1:0]    shift;
      logic [HALF_W-1:0]    hold;
      logic [TIMEOUT_W-1:0] poll;
      logic                 scl;
      logic                 sda;
      logic                 drive;
      logic                 ack;
      logic [BYTE_W-1:0]    rx;
   } eng_state_type;

   localparam eng_state_type STATE_RESET = '{
      phase: PH_IDLE, cmd: KIND_NONE, bits: '0, shift: '0, hold: '0, poll: '0,
      scl: 1'b1, sda: 1'b1, drive: 1'b1, ack: 1'b0, rx: '0
   };

   function automatic eng_state_type enter_phase(eng_state_type s, phase_type p);
      eng_state_type r;
      r       = s;
      r.phase = p;
      r.hold  = '0;
      case (p)
         PH_ST0: begin r.scl = 1'b1; r.sda = 1'b1; r.drive = 1'b1; end
         PH_ST1: r.sda = 1'b0;
         PH_ST2: r.scl = 1'b0;
         PH_SP0: begin r.scl = 1'b0; r.sda = 1'b0; r.drive = 1'b1; end
         PH_SP1: r.scl = 1'b1;
         PH_SP2: r.sda = 1'b1;
         PH_WL: begin
            r.scl   = 1'b0;
            r.drive = 1'b1;
            r.sda   = s.shift[BYTE_W-1];
         end
         PH_WH:  r.scl = 1'b1;
         PH_WT:  r.scl = 1'b0;
         PH_RL0: begin r.scl = 1'b0; r.drive = 1'b0; end
         PH_RH:  r.scl = 1'b1;
         PH_RL:  r.scl = 1'b0;
         PH_AK0: begin r.drive = 1'b1; r.sda = (s.cmd == KIND_NACK); end
         PH_AK1: r.scl = 1'b1;
         PH_AK2: r.scl = 1'b0;
         PH_CK0: begin r.scl = 1'b0; r.drive = 1'b0; end
         PH_CK1: r.scl = 1'b1;
         PH_CKP: r.poll = '0;
         PH_CKT: r.scl = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

   eng_state_type        state_ff;
   eng_state_type        state_in;
   eng_state_type        s;
   logic                 fin;
   logic                 rej;
   logic                 busy;
   logic                 scl_out;
   logic                 sda_out;
   logic                 drv_out;
   logic [HALF_W-1:0]    hp_eff;
   logic [TIMEOUT_W-1:0] to_eff;

   assign hp_eff = (half_period == '0) ? HALF_W'(1) : half_period;
   assign to_eff = (ack_timeout == '0) ? TIMEOUT_W'(1) : ack_timeout;

   always_comb begin
      s   = state_ff;
      rej = 1'b0;
      fin = 1'b0;

      // command launch
      if (s.phase != PH_IDLE) begin
         rej = (kind != KIND_NONE);
      end else if (kind != KIND_NONE) begin
         s.cmd  = kind;
         s.bits = '0;
         case (kind)
            KIND_START: s = enter_phase(s, PH_ST0);
            KIND_STOP:  s = enter_phase(s, PH_SP0);
            KIND_WRITE: begin s.shift = tx_byte; s = enter_phase(s, PH_WL); end
            KIND_READ:  begin s.shift = '0; s = enter_phase(s, PH_RL0); end
            KIND_ACK,
            KIND_NACK:  s = enter_phase(s, PH_AK0);
            default:    s = enter_phase(s, PH_CK0);
         endcase
      end

      busy    = (s.phase != PH_IDLE);
      scl_out = s.scl;
      sda_out = s.sda;
      drv_out = s.drive;

      // phase timing
      if (s.phase == PH_CKP) begin
         if (!sda_in) begin
            s = enter_phase(s, PH_CKT);
         end else begin
            s.poll = s.poll + 1'b1;
            if (s.poll >= to_eff) s = enter_phase(s, PH_SP0);
         end
      end else if (s.phase != PH_IDLE) begin
         s.hold = s.hold + 1'b1;
         if (s.hold >= hp_eff) begin
            case (s.phase)
               PH_ST0: s = enter_phase(s, PH_ST1);
               PH_ST1: s = enter_phase(s, PH_ST2);
               PH_SP0: s = enter_phase(s, PH_SP1);
               PH_SP1: s = enter_phase(s, PH_SP2);
               PH_SP2: begin
                  if (s.cmd == KIND_CHECK) s.ack = 1'b0;
                  fin = 1'b1;
               end
               PH_WL: s = enter_phase(s, PH_WH);
               PH_WH: begin
                  s.shift = {s.shift[BYTE_W-2:0], 1'b0};
                  s.bits  = s.bits + 1'b1;
                  s = enter_phase(s, (s.bits >= 4'd8) ? PH_WT : PH_WL);
               end
               PH_WT: begin s.sda = 1'b1; fin = 1'b1; end
               PH_RL0: s = enter_phase(s, PH_RH);
               PH_RH: begin
                  s.shift = {s.shift[BYTE_W-2:0], sda_in};
                  s = enter_phase(s, PH_RL);
               end
               PH_RL: begin
                  s.bits = s.bits + 1'b1;
                  if (s.bits >= 4'd8) begin
                     s.drive = 1'b1;
                     s.rx    = s.shift;
                     fin     = 1'b1;
                  end else begin
                     s = enter_phase(s, PH_RH);
                  end
               end
               PH_AK0: s = enter_phase(s, PH_AK1);
               PH_AK1: s = enter_phase(s, PH_AK2);
               PH_AK2: begin
                  if (s.cmd == KIND_ACK) s.sda = 1'b1;
                  fin = 1'b1;
               end
               PH_CK0: s = enter_phase(s, PH_CK1);
               PH_CK1: s = enter_phase(s, PH_CKP);
               PH_CKT: begin s.ack = 1'b1; s.drive = 1'b1; fin = 1'b1; end
               default: fin = 1'b1;
            endcase
            if (fin) begin
               s.phase = PH_IDLE;
               s.hold  = '0;
            end
         end
      end

      state_in = step ? s : state_ff;

      res.scl       = scl_out;
      res.sda       = sda_out;
      res.drive     = drv_out;
      res.busy      = busy;
      res.done      = fin;
      res.read_data = s.rx;
      res.ack_seen  = s.ack;
      res.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C master byte sequencer, bound to the top.
// ----------------------------------------------------------------------------
module i2cms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3])
      else $error("done without busy");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[3])
      else $error("rejected while idle");

   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[3])
      else $error("SDA released while idle");

endmodule

bind i2c_master_byte_sequencer_core i2cms_checker u_i2cms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
